@@ design/sbda_pkg.sv @@
// Shared constants and types for the signed binary to decimal ASCII converter.
// No dependencies; imported by sbda_cell and signed_binary_to_decimal_ascii.
`timescale 1ns / 1ps
`default_nettype none

package sbda_pkg;

  localparam int unsigned ValueWidth  = 32;  // input integer width
  localparam int unsigned NumDigits   = 10;  // decimal digits of a 32-bit magnitude
  localparam int unsigned BitsPerStep = 4;   // binary bits folded in per cycle
  localparam int unsigned Steps       = ValueWidth / BitsPerStep;
  localparam int unsigned StepWidth   = $clog2(Steps);
  localparam int unsigned CntWidth    = $clog2(NumDigits + 1);
  localparam int unsigned CharWidth   = 8;

  localparam logic [CharWidth-1:0] CharZero  = 8'd48;  // '0'
  localparam logic [CharWidth-1:0] CharMinus = 8'd45;  // '-'

  // Per-cycle command to every digit cell.
  typedef struct packed {
    logic clear;    // zero the digit
    logic convert;  // fold in BitsPerStep bits (add-3 and shift)
    logic shift;    // take the lower neighbor's digit
  } sbda_ctrl_t;

endpackage : sbda_pkg

`default_nettype wire

@@ design/sbda_cell.sv @@
// One BCD digit cell of the conversion chain: add-3/shift while converting,
// plain digit shift while emitting. Depends on sbda_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbda_cell (
  input  wire logic                                clk_i,
  input  wire sbda_pkg::sbda_ctrl_t                ctrl_i,
  input  wire logic [sbda_pkg::BitsPerStep-1:0]    bits_i,   // from lower digit, MSB first
  output logic      [sbda_pkg::BitsPerStep-1:0]    bits_o,   // to upper digit, MSB first
  input  wire logic [3:0]                          digit_i,  // lower neighbor's digit
  output logic      [3:0]                          digit_o
);
  import sbda_pkg::*;

  logic [3:0] digit_q, digit_d;
  logic [3:0] conv_digit;

  // Double dabble over BitsPerStep sub-steps: adjust, pass out MSB, shift in.
  always_comb begin
    logic [3:0] d;
    d = digit_q;
    bits_o = '0;
    for (int j = BitsPerStep - 1; j >= 0; j--) begin
      if (d >= 4'd5) begin
        d = d + 4'd3;
      end
      bits_o[j] = d[3];
      d = {d[2:0], bits_i[j]};
    end
    conv_digit = d;
  end

  always_comb begin
    digit_d = digit_q;
    if (ctrl_i.clear) begin
      digit_d = '0;
    end else if (ctrl_i.convert) begin
      digit_d = conv_digit;
    end else if (ctrl_i.shift) begin
      digit_d = digit_i;
    end
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

  assign digit_o = digit_q;

endmodule : sbda_cell

`default_nettype wire

@@ design/signed_binary_to_decimal_ascii.sv @@
// Top level of the signed 32-bit integer to decimal ASCII converter.
// Depends on sbda_pkg and sbda_cell (a chain of ten BCD digit cells).
`timescale 1ns / 1ps
`default_nettype none

// Converts one signed 32-bit value per input transfer into its decimal text,
// one ASCII character per output transfer, most significant first, with last_o
// set on the final character. Negative values start with '-', zero gives a
// single '0', leading zeros are dropped, and -2147483648 comes out correctly
// as eleven characters. Internally the magnitude is fed four bits per cycle
// into a row of ten BCD digit cells (add-3 and shift); the chain then shifts
// one digit position per cycle toward the top cell, dropping leading zeros and
// sending each remaining digit to the output register, and holds while the '-'
// is pending or while a digit waits for a free output register. The '-' goes
// out as soon as the output is free, usually during conversion. The input is
// stalled while an item is in work, and a new value is taken in the cycle
// after the last character is loaded into the output register, even while
// that character still waits for its transfer.
module signed_binary_to_decimal_ascii (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic signed [sbda_pkg::ValueWidth-1:0] value_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic      [sbda_pkg::CharWidth-1:0]     character_o,
  output logic                                    last_o
);
  import sbda_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StConv = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;

  // Control state
  logic [1:0]           state_q, state_d;
  logic [StepWidth-1:0] step_q, step_d;     // conversion steps left minus one
  logic [CntWidth-1:0]  cnt_q, cnt_d;       // digit positions left to scan
  logic                 started_q, started_d;  // a significant digit went out
  logic                 neg_q, neg_d;       // '-' still to send
  logic                 out_valid_q, out_valid_d;

  // Payload
  logic [ValueWidth-1:0] mag_q, mag_d;
  logic [CharWidth-1:0]  char_q, char_d;
  logic                  last_q, last_d;

  // Cell chain wiring
  sbda_ctrl_t             ctrl;
  logic [BitsPerStep-1:0] cell_bits [0:NumDigits];
  logic [3:0]             cell_digit [0:NumDigits-1];
  logic [3:0]             top_digit;

  logic                  in_accept;
  logic                  out_free;
  logic                  lead_zero;
  logic [ValueWidth-1:0] raw;

  assign raw       = ValueWidth'(value_i);
  assign in_accept = in_valid_i && (state_q == StIdle);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign top_digit = cell_digit[NumDigits-1];
  assign lead_zero = (top_digit == 4'd0) && !started_q && (cnt_q > CntWidth'(1));

  // Magnitude bits enter the lowest digit, most significant first.
  assign cell_bits[0] = mag_q[ValueWidth-1 -: BitsPerStep];

  for (genvar k = 0; k < NumDigits; k++) begin : g_cell
    logic [3:0] lower_digit;
    if (k == 0) begin : g_first
      assign lower_digit = 4'd0;
    end else begin : g_rest
      assign lower_digit = cell_digit[k-1];
    end
    sbda_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .bits_i  (cell_bits[k]),
      .bits_o  (cell_bits[k+1]),
      .digit_i (lower_digit),
      .digit_o (cell_digit[k])
    );
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    cnt_d       = cnt_q;
    started_d   = started_q;
    neg_d       = neg_q;
    mag_d       = mag_q;
    char_d      = char_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && out_stall_i;
    ctrl        = '0;

    case (state_q)
      StIdle: begin
        if (in_accept) begin
          neg_d     = raw[ValueWidth-1];
          mag_d     = raw[ValueWidth-1] ? (ValueWidth'(0) - raw) : raw;
          step_d    = StepWidth'(Steps - 1);
          cnt_d     = CntWidth'(NumDigits);
          started_d = 1'b0;
          ctrl.clear = 1'b1;
          state_d   = StConv;
        end
      end
      StConv: begin
        ctrl.convert = 1'b1;
        mag_d = mag_q << BitsPerStep;
        if (step_q == '0) begin
          state_d = StEmit;
        end else begin
          step_d = step_q - StepWidth'(1);
        end
      end
      StEmit: begin
        if (!neg_q) begin
          if (lead_zero) begin
            ctrl.shift = 1'b1;
            cnt_d = cnt_q - CntWidth'(1);
          end else if (out_free) begin
            ctrl.shift  = 1'b1;
            cnt_d       = cnt_q - CntWidth'(1);
            started_d   = 1'b1;
            char_d      = CharZero + CharWidth'(top_digit);
            last_d      = (cnt_q == CntWidth'(1));
            out_valid_d = 1'b1;
            if (cnt_q == CntWidth'(1)) begin
              state_d = StIdle;
            end
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    // The sign goes out as soon as the output is free, ahead of any digit.
    if ((state_q != StIdle) && neg_q && out_free) begin
      neg_d       = 1'b0;
      char_d      = CharMinus;
      last_d      = 1'b0;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= '0;
      cnt_q       <= '0;
      started_q   <= 1'b0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      cnt_q       <= cnt_d;
      started_q   <= started_d;
      neg_q       <= neg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

  // A 32-bit magnitude always fits ten digits: nothing leaves the top cell.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StConv) |-> (cell_bits[NumDigits] == '0))
    else $error("carry out of the top digit cell");

  // The sign must be sent before the block can go idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> !neg_q)
    else $error("sign still pending while idle");

  // Loading the final character frees the input on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == StEmit) && !neg_q && !lead_zero && out_free && (cnt_q == CntWidth'(1)))
    |=> (!in_stall_o && out_valid_o && last_o))
    else $error("last character did not end the item");

  // Only '-' or a decimal digit is ever presented.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((character_o == CharMinus) ||
                     ((character_o >= CharZero) && (character_o <= CharZero + 8'd9))))
    else $error("non-decimal character presented");

endmodule : signed_binary_to_decimal_ascii

`default_nettype wire

@@ tb/signed_binary_to_decimal_ascii_tb.sv @@
// Testbench for signed_binary_to_decimal_ascii: checks the decimal ASCII text
// of signed 32-bit values against a built-in predictor, under random stalls.
// Depends on sbda_pkg and the signed_binary_to_decimal_ascii RTL.
`timescale 1ns / 1ps

module signed_binary_to_decimal_ascii_tb;

  import sbda_pkg::*;

  // Base of the printed number.
  localparam int unsigned Radix = 10;
  // Random numbers after the directed set.
  localparam int RandomItems = 260;
  // Idling stops once this few numbers are left to send.
  localparam int TailItems = 40;
  // Long receiver hold-off, starts after this many input transfers.
  localparam int HoldAfterItems = 80;
  localparam int HoldCycles = 200;
  // Settle time at the end: comfortably longer than one unstalled item takes.
  localparam int SettleCycles = 4 * NumDigits;

  // One number to send; hold_for_drain makes the sender wait until all
  // outstanding characters have come back before offering it.
  typedef struct {
    logic signed [ValueWidth-1:0] value;
    bit                           hold_for_drain;
  } num_item_t;

  // One expected character of a number's text.
  typedef struct {
    logic [CharWidth-1:0] code;
    logic                 last;
  } text_char_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [ValueWidth-1:0] value_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [CharWidth-1:0] character_o;
  logic last_o;

  num_item_t  numbers_to_send[$];
  text_char_t expected_chars[$];
  num_item_t  next_number;

  int  send_gap = 0;        // sender idle cycles left
  int  stall_left = 0;      // receiver stall cycles left after this one
  bit  tail_phase = 1'b0;   // no idling on either side once set
  bit  receiver_hold = 1'b0;
  int  numbers_sent = 0;
  int  negatives_sent = 0;
  int  chars_checked = 0;
  int  text_len = 0;
  int  longest_text = 0;
  int  mismatches = 0;

  signed_binary_to_decimal_ascii dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .character_o (character_o),
    .last_o      (last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 50) begin
      $display("ERROR at %0t ns: %s", $time, what);
    end
  endtask

  // Appends the expected text of one accepted number: optional '-', then the
  // magnitude's digits, most significant first. The magnitude is taken as an
  // unsigned 32-bit value so the most negative number comes out right.
  function automatic void predict_text(input logic [ValueWidth-1:0] raw);
    logic [ValueWidth-1:0] mag;
    logic [CharWidth-1:0]  digits[NumDigits];
    int nd;
    mag = raw[ValueWidth-1] ? (ValueWidth'(0) - raw) : raw;
    nd = 0;
    do begin
      digits[nd] = CharZero + CharWidth'(mag % Radix);
      mag = mag / Radix;
      nd++;
    end while (mag != 0 && nd < NumDigits);
    if (raw[ValueWidth-1]) begin
      expected_chars.push_back('{code: CharMinus, last: 1'b0});
    end
    for (int k = nd - 1; k >= 0; k--) begin
      expected_chars.push_back('{code: digits[k], last: (k == 0)});
    end
  endfunction

  // Random number with a spread of text lengths: raw 32-bit patterns (every
  // bit toggles), decade edges such as 1000 and 999, and values of a chosen
  // digit count.
  function automatic logic signed [ValueWidth-1:0] random_number();
    longint lo;
    longint hi;
    longint mag;
    int n;
    lo = 1;
    case ($urandom_range(0, 9))
      0, 1: return $urandom;
      2: begin
        n = $urandom_range(0, NumDigits - 1);
        for (int i = 0; i < n; i++) lo = lo * Radix;
        mag = $urandom_range(0, 1) ? lo : lo - 1;
      end
      default: begin
        n = $urandom_range(1, NumDigits);
        for (int i = 1; i < n; i++) lo = lo * Radix;
        hi = lo * Radix - 1;
        if (hi > 64'sd2147483647) hi = 64'sd2147483647;
        mag = $urandom_range(int'(hi), int'(lo));
      end
    endcase
    return $urandom_range(0, 1) ? -ValueWidth'(mag) : ValueWidth'(mag);
  endfunction

  // Sender. An input transfer happens at an edge where valid is high and the
  // block's stall is low; the predictor runs on the value seen at that edge.
  // A held value stays put until it is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      value_i    <= '0;
      tail_phase <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_text(value_i);
        numbers_sent++;
        if (value_i < 0) negatives_sent++;
      end
      tail_phase <= (numbers_to_send.size() < TailItems);
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (numbers_to_send.size() != 0 &&
                     !(numbers_to_send[0].hold_for_drain && expected_chars.size() != 0)) begin
          next_number = numbers_to_send.pop_front();
          in_valid_i <= 1'b1;
          value_i    <= next_number.value;
          // Gap after this number, taken once it has been transferred.
          if (!tail_phase && $urandom_range(0, 5) == 0) begin
            send_gap = $urandom_range(1, 11);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver. Each output transfer is checked against the oldest expected
  // character; stall comes in random bursts, or held for the long hold-off.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        chars_checked++;
        text_len++;
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected character %0d last=%0b",
                                    character_o, last_o));
        end else begin
          if (character_o !== expected_chars[0].code) begin
            report_mismatch($sformatf("character %0d, expected %0d",
                                      character_o, expected_chars[0].code));
          end
          if (last_o !== expected_chars[0].last) begin
            report_mismatch($sformatf("last %0b, expected %0b on character %0d",
                                      last_o, expected_chars[0].last,
                                      expected_chars[0].code));
          end
          void'(expected_chars.pop_front());
        end
        if (last_o === 1'b1) begin
          if (text_len > longest_text) longest_text = text_len;
          text_len = 0;
        end
      end
      if (receiver_hold) begin
        out_stall_i <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (!tail_phase && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 10);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Long receiver hold-off: the block fills up and must stall its input while
  // the sender keeps offering numbers.
  initial begin
    while (numbers_sent < HoldAfterItems) @(posedge clk_i);
    receiver_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    receiver_hold <= 1'b0;
  end

  initial begin
    #5ms;
    $display("Timeout: %0d characters still expected", expected_chars.size());
    $display("Simulation FAILED");
    $finish;
  end

  // Stimulus and end of run.
  initial begin
    logic signed [ValueWidth-1:0] directed[$];
    directed = '{32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10, 32'sd99,
                 32'sd100, -32'sd5, 32'sd2147483647, 32'h8000_0000,
                 -32'sd2147483647, 32'sd1000000000, 32'sd999999999,
                 -32'sd999999999, 32'sd1234567890, -32'sd1234567890,
                 32'sd7, 32'h5555_5555, 32'hAAAA_AAAA};
    foreach (directed[i]) begin
      numbers_to_send.push_back('{value: directed[i], hold_for_drain: 1'b0});
    end
    for (int i = 0; i < RandomItems; i++) begin
      // Sender waits for a full drain at the start and middle of the random part.
      numbers_to_send.push_back('{value: random_number(),
                                  hold_for_drain: (i == 0 || i == RandomItems / 2)});
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (numbers_to_send.size() != 0 || in_valid_i || expected_chars.size() != 0) begin
      @(posedge clk_i);
    end
    // Any stray character after the last one shows up as unexpected here.
    repeat (SettleCycles) @(posedge clk_i);

    $display("Converted %0d numbers (%0d negative) into %0d checked characters,",
             numbers_sent, negatives_sent, chars_checked);
    $display("longest text %0d characters, with a %0d-cycle output hold-off and drain pauses.",
             longest_text, HoldCycles);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
